// ===== design/arw_pkg.sv =====
// Shared constants, types and codes for the anti-replay window.
package arw_pkg;

	// Window size, rounded up to whole 64-bit bitmap words.
	localparam int WINDOW_BITS  = 1024;
	localparam int WORD_BITS    = 64;
	localparam int BIT_IDX_W    = $clog2(WORD_BITS);
	localparam int WINDOW_WORDS = (WINDOW_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam logic [63:0] WINDOW_SPAN = 64'(WINDOW_WORDS * WORD_BITS);

	// The ring holds one word per 64-number block. The window touches at most
	// one block more than its word count, so the ring is the smallest power of two at or above that.
	localparam int RING_DEPTH = 2 ** $clog2(WINDOW_WORDS + 1);
	localparam int RING_IDX_W = $clog2(RING_DEPTH);
	localparam int BLOCK_W    = 64 - BIT_IDX_W;
	localparam int TAG_W      = BLOCK_W - RING_IDX_W;

	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	// Stream widths.
	localparam int OUT_FIELDS_W = 2 + 64 + 32 + 32;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

	typedef enum logic {
		OP_CHECK = 1'b0,
		OP_CLEAR = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT = 2'd0,
		VERDICT_DUP    = 2'd1,
		VERDICT_OLD    = 2'd2
	} verdict_t;

	// One ring word: the block tag and the seen bits of that block.
	typedef struct packed {
		logic [TAG_W-1:0]     tag;
		logic [WORD_BITS-1:0] bits;
	} ring_entry_t;

	typedef struct packed {
		logic                  rd_en;
		logic [RING_IDX_W-1:0] rd_addr;
		logic                  wr_en;
		logic [RING_IDX_W-1:0] wr_addr;
		ring_entry_t           wr_data;
		logic                  clear;
	} ring_req_t;

	typedef struct packed {
		logic        valid;
		ring_entry_t entry;
	} ring_rsp_t;

	typedef struct packed {
		logic [31:0] old_count;
		logic [31:0] dup_count;
		logic [63:0] highest;
		verdict_t    verdict;
	} result_t;

endpackage

// ===== design/arw_ring_store.sv =====
// Ring of tagged bitmap words with per-entry valid bits and a registered read port.
module arw_ring_store import arw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ring_req_t req,
	output ring_rsp_t rsp
);

	ring_entry_t           mem [RING_DEPTH];
	ring_entry_t           rd_entry_q;
	logic                  rd_valid_q;
	logic [RING_DEPTH-1:0] valid_q;

	// Word storage: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_entry_q <= mem[req.rd_addr];
		end
	end

	// Valid bits are cleared at once by reset or by a window clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rsp.valid = rd_valid_q;
	assign rsp.entry = rd_entry_q;

endmodule

// ===== design/arw_window_ctrl.sv =====
// Window decision logic: highest number, counters and read-modify-write of the ring.
module arw_window_ctrl import arw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  op_t         op,
	input  logic [63:0] seq,
	input  logic        done,
	output ring_req_t   ring_req,
	input  ring_rsp_t   ring_rsp,
	output result_t     result
);

	op_t         op_s1;
	logic [63:0] seq_s1;
	logic        ahead_s1;
	logic        far_s1;

	logic [63:0] highest_q;
	logic        any_seen_q;
	logic [31:0] dup_q;
	logic [31:0] old_q;

	logic [63:0]          back;
	logic                 hit;
	logic [WORD_BITS-1:0] old_bits;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] new_bits;
	logic                 seen;
	verdict_t             verdict_d;
	logic [63:0]          highest_d;
	logic                 any_seen_d;
	logic [31:0]          dup_d;
	logic [31:0]          old_d;
	logic                 wr_d;
	logic                 clear_d;

	// Accept stage: compare against the highest number while the ring read is in flight.
	assign back = highest_q - seq;

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= op;
			seq_s1   <= seq;
			ahead_s1 <= seq > highest_q;
			far_s1   <= back >= WINDOW_SPAN;
		end
	end

	// Completion stage: the word is valid for this number only when its tag matches.
	assign hit      = ring_rsp.valid && (ring_rsp.entry.tag == seq_s1[63 -: TAG_W]);
	assign old_bits = hit ? ring_rsp.entry.bits : '0;
	assign mask     = {{(WORD_BITS-1){1'b0}}, 1'b1} << seq_s1[BIT_IDX_W-1:0];
	assign new_bits = old_bits | mask;
	assign seen     = |(old_bits & mask);

	// Verdict and next state.
	always_comb begin
		verdict_d  = VERDICT_ACCEPT;
		highest_d  = highest_q;
		any_seen_d = any_seen_q;
		dup_d      = dup_q;
		old_d      = old_q;
		wr_d       = 1'b0;
		clear_d    = 1'b0;
		if (op_s1 == OP_CLEAR) begin
			highest_d  = '0;
			any_seen_d = 1'b0;
			dup_d      = '0;
			old_d      = '0;
			clear_d    = 1'b1;
		end else if (!any_seen_q || ahead_s1) begin
			highest_d  = seq_s1;
			any_seen_d = 1'b1;
			wr_d       = 1'b1;
		end else if (far_s1) begin
			verdict_d = VERDICT_OLD;
			old_d     = (old_q == CNT_MAX) ? old_q : old_q + 32'd1;
		end else if (seen) begin
			verdict_d = VERDICT_DUP;
			dup_d     = (dup_q == CNT_MAX) ? dup_q : dup_q + 32'd1;
		end else begin
			wr_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			highest_q  <= '0;
			any_seen_q <= 1'b0;
			dup_q      <= '0;
			old_q      <= '0;
		end else if (done) begin
			highest_q  <= highest_d;
			any_seen_q <= any_seen_d;
			dup_q      <= dup_d;
			old_q      <= old_d;
		end
	end

	// Ring requests: read on accept, write back or clear on completion.
	assign ring_req.rd_en         = accept;
	assign ring_req.rd_addr       = seq[BIT_IDX_W +: RING_IDX_W];
	assign ring_req.wr_en         = done && wr_d;
	assign ring_req.wr_addr       = seq_s1[BIT_IDX_W +: RING_IDX_W];
	assign ring_req.wr_data.tag   = seq_s1[63 -: TAG_W];
	assign ring_req.wr_data.bits  = new_bits;
	assign ring_req.clear         = done && clear_d;

	assign result.verdict   = verdict_d;
	assign result.highest   = highest_d;
	assign result.dup_count = dup_d;
	assign result.old_count = old_d;

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && done))
		else $error("request accepted while another completes");

	a_clear_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		ring_req.clear |-> !ring_req.wr_en)
		else $error("ring write during window clear");

	a_highest_rises: assert property (@(posedge clk) disable iff (!arst_n)
		done && op_s1 == OP_CHECK && any_seen_q |=> highest_q >= $past(highest_q))
		else $error("highest number moved backward");

	a_dup_counted: assert property (@(posedge clk) disable iff (!arst_n)
		done && verdict_d == VERDICT_DUP |=>
		(dup_q == $past(dup_q) + 32'd1) || (dup_q == CNT_MAX))
		else $error("duplicate not counted");

endmodule

// ===== design/anti_replay_window.sv =====
// Anti-replay sliding window, top level.
// On accept the number and the ring read are registered; the result is then formed and taken
// into the output register on completion. No new request is taken until the last one completes.
// A finished result waits in the output register; the next request is taken meanwhile.
// Reset (arst_n low) empties the window, zeroes the highest number and both counters.
module anti_replay_window import arw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [63:0]           s_tdata,  // [63:0] seq_number
	input  logic [0:0]            s_tuser,  // [0] operation
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// [1:0] verdict, [65:2] highest_seq, [97:66] duplicate_count,
	// [129:98] too_old_count, upper bits zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic                  busy_q;
	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;
	logic                  accept;
	logic                  done;
	ring_req_t             ring_req;
	ring_rsp_t             ring_rsp;
	result_t               result;

	// Handshake: one request in flight; it completes once the output slot is free.
	assign s_tready = !busy_q;
	assign accept   = s_tvalid && s_tready;
	assign done     = busy_q && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata_q <= OUT_DATA_W'(result);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	arw_window_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.op       (op_t'(s_tuser[0])),
		.seq      (s_tdata),
		.done     (done),
		.ring_req (ring_req),
		.ring_rsp (ring_rsp),
		.result   (result)
	);

	arw_ring_store u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ring_req),
		.rsp    (ring_rsp)
	);

endmodule
